// File: src/ncps_pkg.sv
`default_nettype none

package ncps_pkg;

	localparam logic [1:0] COLOR_BLUE   = 2'd0;
	localparam logic [1:0] COLOR_YELLOW = 2'd1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

endpackage

`default_nettype wire

// File: src/ncps_if.sv
`default_nettype none

interface ncps_in_if #(
	parameter int COORD_WIDTH   = 24,
	parameter int HEADING_WIDTH = 16
);
	logic                            valid;
	logic                            ready;
	logic signed [COORD_WIDTH-1:0]   car_x;
	logic signed [COORD_WIDTH-1:0]   car_y;
	logic signed [HEADING_WIDTH-1:0] heading_cos;
	logic signed [HEADING_WIDTH-1:0] heading_sin;
	logic signed [COORD_WIDTH-1:0]   cone_x;
	logic signed [COORD_WIDTH-1:0]   cone_y;
	logic [1:0]                      cone_color;
	logic                            last_cone;

	modport source (
		output valid, car_x, car_y, heading_cos, heading_sin, cone_x, cone_y,
		       cone_color, last_cone,
		input  ready
	);
	modport sink (
		input  valid, car_x, car_y, heading_cos, heading_sin, cone_x, cone_y,
		       cone_color, last_cone,
		output ready
	);
endinterface

interface ncps_out_if #(
	parameter int COORD_WIDTH = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] blue_x;
	logic signed [COORD_WIDTH-1:0] blue_y;
	logic signed [COORD_WIDTH-1:0] yellow_x;
	logic signed [COORD_WIDTH-1:0] yellow_y;
	logic signed [COORD_WIDTH:0]   mid_x;
	logic signed [COORD_WIDTH:0]   mid_y;

	modport source (
		output valid, blue_x, blue_y, yellow_x, yellow_y, mid_x, mid_y,
		input  ready
	);
	modport sink (
		input  valid, blue_x, blue_y, yellow_x, yellow_y, mid_x, mid_y,
		output ready
	);
endinterface

`default_nettype wire

// File: src/ncps_front.sv
`default_nettype none

module ncps_front #(
	parameter int COORD_WIDTH   = 24,
	parameter int HEADING_WIDTH = 16,
	localparam int DiffW  = COORD_WIDTH + 1,
	localparam int ProdW  = HEADING_WIDTH + DiffW,
	localparam int DotW   = ProdW + 1,
	localparam int DistW  = 2 * DiffW,
	localparam int EntryW = 3 + 2 * COORD_WIDTH + DistW
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	ncps_in_if.sink                cone_in,
	output logic                   push_valid,
	output logic [EntryW-1:0]      push_data,
	input  wire logic              push_ready
);

	logic advance;

	logic valid_s1, valid_s2, valid_s3;

	logic signed [DiffW-1:0]         dx_s1, dy_s1;
	logic signed [HEADING_WIDTH-1:0] hc_s1, hs_s1;
	logic signed [COORD_WIDTH-1:0]   x_s1, y_s1;
	logic                            ranked_s1, yellow_s1, last_s1;

	logic signed [ProdW-1:0]         dotc_s2, dots_s2;
	logic signed [DistW-1:0]         sqx_s2, sqy_s2;
	logic signed [COORD_WIDTH-1:0]   x_s2, y_s2;
	logic                            ranked_s2, yellow_s2, last_s2;

	logic [DistW-1:0]                dist_s3;
	logic signed [COORD_WIDTH-1:0]   x_s3, y_s3;
	logic                            keep_s3, yellow_s3, last_s3;

	logic signed [DotW-1:0]          dot_sum;

	assign advance       = !valid_s3 || push_ready;
	assign cone_in.ready = advance;
	assign dot_sum       = DotW'(dotc_s2) + DotW'(dots_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= cone_in.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			dx_s1     <= DiffW'(cone_in.cone_x) - DiffW'(cone_in.car_x);
			dy_s1     <= DiffW'(cone_in.cone_y) - DiffW'(cone_in.car_y);
			hc_s1     <= cone_in.heading_cos;
			hs_s1     <= cone_in.heading_sin;
			x_s1      <= cone_in.cone_x;
			y_s1      <= cone_in.cone_y;
			ranked_s1 <= (cone_in.cone_color == ncps_pkg::COLOR_BLUE) ||
			             (cone_in.cone_color == ncps_pkg::COLOR_YELLOW);
			yellow_s1 <= cone_in.cone_color == ncps_pkg::COLOR_YELLOW;
			last_s1   <= cone_in.last_cone;

			dotc_s2   <= ProdW'(hc_s1) * ProdW'(dx_s1);
			dots_s2   <= ProdW'(hs_s1) * ProdW'(dy_s1);
			sqx_s2    <= DistW'(dx_s1) * DistW'(dx_s1);
			sqy_s2    <= DistW'(dy_s1) * DistW'(dy_s1);
			x_s2      <= x_s1;
			y_s2      <= y_s1;
			ranked_s2 <= ranked_s1;
			yellow_s2 <= yellow_s1;
			last_s2   <= last_s1;

			// A cone counts only when it lies strictly ahead of the car.
			keep_s3   <= ranked_s2 && (dot_sum > 0);
			dist_s3   <= $unsigned(sqx_s2) + $unsigned(sqy_s2);
			x_s3      <= x_s2;
			y_s3      <= y_s2;
			yellow_s3 <= yellow_s2;
			last_s3   <= last_s2;
		end
	end

	assign push_valid = valid_s3;
	assign push_data  = {last_s3, keep_s3, yellow_s3, x_s3, y_s3, dist_s3};

endmodule

`default_nettype wire

// File: src/ncps_queue.sv
`default_nettype none

module ncps_queue #(
	parameter int DATA_WIDTH = 101
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push_valid,
	input  wire logic [DATA_WIDTH-1:0] push_data,
	output logic                       push_ready,
	output logic                       pop_valid,
	output logic [DATA_WIDTH-1:0]      pop_data,
	input  wire logic                  pop_ready
);

	logic [DATA_WIDTH-1:0]            entries_q [ncps_pkg::QUEUE_DEPTH];
	logic [ncps_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [ncps_pkg::QUEUE_CNT_W-1:0] count_q;
	logic                             do_push, do_pop;

	assign push_ready = count_q != ncps_pkg::QUEUE_CNT_W'(ncps_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// File: src/ncps_back.sv
`default_nettype none

module ncps_back #(
	parameter int COORD_WIDTH = 24,
	localparam int DiffW  = COORD_WIDTH + 1,
	localparam int DistW  = 2 * DiffW,
	localparam int EntryW = 3 + 2 * COORD_WIDTH + DistW
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pop_valid,
	input  wire logic [EntryW-1:0] pop_data,
	output logic                   pop_ready,
	ncps_out_if.source             pair_out
);

	logic [DistW-1:0]              e_dist;
	logic [COORD_WIDTH-1:0]        e_x, e_y;
	logic                          e_yellow, e_keep, e_last;
	logic                          do_pop, take_blue, take_yellow, emit;
	logic                          nb_found, ny_found;
	logic [COORD_WIDTH-1:0]        nb_x, nb_y, ny_x, ny_y;

	logic                          blue_found_q, yellow_found_q;
	logic [DistW-1:0]              blue_dist_q, yellow_dist_q;
	logic [COORD_WIDTH-1:0]        blue_x_q, blue_y_q, yellow_x_q, yellow_y_q;

	logic                          out_valid_q;
	logic signed [COORD_WIDTH-1:0] out_bx_q, out_by_q, out_yx_q, out_yy_q;
	logic signed [COORD_WIDTH:0]   out_mx_q, out_my_q;

	assign e_dist   = pop_data[DistW-1:0];
	assign e_y      = pop_data[DistW +: COORD_WIDTH];
	assign e_x      = pop_data[DistW + COORD_WIDTH +: COORD_WIDTH];
	assign e_yellow = pop_data[DistW + 2 * COORD_WIDTH];
	assign e_keep   = pop_data[DistW + 2 * COORD_WIDTH + 1];
	assign e_last   = pop_data[DistW + 2 * COORD_WIDTH + 2];

	assign pop_ready = !out_valid_q || pair_out.ready;
	assign do_pop    = pop_valid && pop_ready;

	// On equal distance the cone already kept stays.
	assign take_blue   = e_keep && !e_yellow && (!blue_found_q || (e_dist < blue_dist_q));
	assign take_yellow = e_keep && e_yellow && (!yellow_found_q || (e_dist < yellow_dist_q));

	assign nb_found = blue_found_q || take_blue;
	assign ny_found = yellow_found_q || take_yellow;
	assign nb_x     = take_blue ? e_x : blue_x_q;
	assign nb_y     = take_blue ? e_y : blue_y_q;
	assign ny_x     = take_yellow ? e_x : yellow_x_q;
	assign ny_y     = take_yellow ? e_y : yellow_y_q;
	assign emit     = do_pop && e_last && nb_found && ny_found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blue_found_q   <= 1'b0;
			yellow_found_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (do_pop) begin
				blue_found_q   <= nb_found && !e_last;
				yellow_found_q <= ny_found && !e_last;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pair_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop && take_blue) begin
			blue_dist_q <= e_dist;
			blue_x_q    <= e_x;
			blue_y_q    <= e_y;
		end
		if (do_pop && take_yellow) begin
			yellow_dist_q <= e_dist;
			yellow_x_q    <= e_x;
			yellow_y_q    <= e_y;
		end
		if (emit) begin
			out_bx_q <= $signed(nb_x);
			out_by_q <= $signed(nb_y);
			out_yx_q <= $signed(ny_x);
			out_yy_q <= $signed(ny_y);
			out_mx_q <= DiffW'($signed(nb_x)) + DiffW'($signed(ny_x));
			out_my_q <= DiffW'($signed(nb_y)) + DiffW'($signed(ny_y));
		end
	end

	assign pair_out.valid    = out_valid_q;
	assign pair_out.blue_x   = out_bx_q;
	assign pair_out.blue_y   = out_by_q;
	assign pair_out.yellow_x = out_yx_q;
	assign pair_out.yellow_y = out_yy_q;
	assign pair_out.mid_x    = out_mx_q;
	assign pair_out.mid_y    = out_my_q;

endmodule

`default_nettype wire

// File: src/nearest_front_cone_pair_select_core.sv
// A result is registered at the back end's output once the frame's last cone is popped.
// Throughput: one cone per cycle without stalls; the three-stage front pipeline multiplies
// offsets and heading, and the back end does one compare-update per cycle while unstalled.
// A four-entry queue decouples the two, so each side stalls on its own.
// Reset: asynchronous active-low; it empties the pipeline and queue and clears the found flags.
`default_nettype none

module nearest_front_cone_pair_select_core #(
	parameter int COORD_WIDTH   = 24,
	parameter int HEADING_WIDTH = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ncps_in_if.sink    cone_in,
	ncps_out_if.source pair_out
);

	localparam int EntryW = 3 + 2 * COORD_WIDTH + 2 * (COORD_WIDTH + 1);

	logic              push_valid, push_ready, pop_valid, pop_ready;
	logic [EntryW-1:0] push_data, pop_data;

	ncps_front #(
		.COORD_WIDTH   (COORD_WIDTH),
		.HEADING_WIDTH (HEADING_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cone_in    (cone_in),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	ncps_queue #(
		.DATA_WIDTH (EntryW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	ncps_back #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.pop_ready (pop_ready),
		.pair_out  (pair_out)
	);

endmodule

`default_nettype wire

// File: src/ncps_checker.sv
`default_nettype none

module ncps_checker #(
	parameter int COORD_WIDTH = 24
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic signed [COORD_WIDTH-1:0] blue_x,
	input wire logic signed [COORD_WIDTH-1:0] blue_y,
	input wire logic signed [COORD_WIDTH-1:0] yellow_x,
	input wire logic signed [COORD_WIDTH-1:0] yellow_y,
	input wire logic signed [COORD_WIDTH:0]   mid_x,
	input wire logic signed [COORD_WIDTH:0]   mid_y
);

	localparam int SumW = COORD_WIDTH + 1;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(blue_x) && $stable(blue_y) &&
		$stable(yellow_x) && $stable(yellow_y))
		else $error("result payload changed while stalled");

	a_mid_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mid_x == SumW'(blue_x) + SumW'(yellow_x))
		else $error("mid_x is not the sum of the selected x coordinates");

	a_mid_y: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> mid_y == SumW'(blue_y) + SumW'(yellow_y))
		else $error("mid_y is not the sum of the selected y coordinates");

endmodule

bind nearest_front_cone_pair_select_core ncps_checker #(
	.COORD_WIDTH (COORD_WIDTH)
) u_ncps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (pair_out.valid),
	.out_ready (pair_out.ready),
	.blue_x    (pair_out.blue_x),
	.blue_y    (pair_out.blue_y),
	.yellow_x  (pair_out.yellow_x),
	.yellow_y  (pair_out.yellow_y),
	.mid_x     (pair_out.mid_x),
	.mid_y     (pair_out.mid_y)
);

`default_nettype wire
